/* hw/rtl/tgp_pkg.sv */
package tgp_pkg;

  localparam logic [4:0] TileLast = 5'd30;
  localparam logic [4:0] NumTop   = 5'd12;
  localparam logic [4:0] NumBot   = 5'd18;
  localparam logic [4:0] UnitsCol = 5'd20;
  localparam logic [4:0] LastCol  = 5'd24;
  localparam logic [4:0] DigitW   = 5'd5;

  localparam logic [3:0] ArrowNone = 4'd0;
  localparam logic [3:0] ArrowLast = 4'd8;

  // q / 10 == (q * Recip10) >> 23, exact for all q below 2**22.
  localparam logic [19:0] Recip10   = 20'd838861;
  localparam int          RecipShft = 23;

  // One font row per entry; bit 4 is the leftmost column, a one is a black cell.
  localparam logic [4:0] FontRows [10][7] = '{
    '{5'h0C, 5'h12, 5'h12, 5'h12, 5'h12, 5'h12, 5'h0C},
    '{5'h04, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1E},
    '{5'h0C, 5'h12, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1E},
    '{5'h0C, 5'h12, 5'h02, 5'h0C, 5'h02, 5'h12, 5'h0C},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1E, 5'h02, 5'h02},
    '{5'h1E, 5'h10, 5'h10, 5'h1C, 5'h02, 5'h12, 5'h0C},
    '{5'h0C, 5'h12, 5'h10, 5'h1C, 5'h12, 5'h12, 5'h0C},
    '{5'h1E, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0C, 5'h12, 5'h12, 5'h0C, 5'h12, 5'h12, 5'h0C},
    '{5'h0C, 5'h12, 5'h12, 5'h0E, 5'h02, 5'h12, 5'h0C}
  };

  // Arrow patterns; short patterns repeat their last cell.
  localparam logic [4:0] ArrowRow [9][7] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd2,  5'd2,  5'd2,  5'd2,  5'd3,  5'd4,  5'd5 },
    '{5'd1,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd3 },
    '{5'd2,  5'd2,  5'd2,  5'd2,  5'd3,  5'd4,  5'd5 },
    '{5'd15, 5'd14, 5'd16, 5'd13, 5'd17, 5'd17, 5'd17},
    '{5'd15, 5'd14, 5'd16, 5'd13, 5'd17, 5'd17, 5'd17},
    '{5'd28, 5'd28, 5'd28, 5'd28, 5'd27, 5'd26, 5'd25},
    '{5'd29, 5'd28, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27},
    '{5'd28, 5'd28, 5'd28, 5'd28, 5'd27, 5'd26, 5'd25}
  };
  localparam logic [4:0] ArrowCol [9][7] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0 },
    '{5'd2,  5'd3,  5'd4,  5'd5,  5'd2,  5'd2,  5'd2 },
    '{5'd15, 5'd14, 5'd16, 5'd13, 5'd17, 5'd17, 5'd17},
    '{5'd27, 5'd26, 5'd25, 5'd24, 5'd27, 5'd27, 5'd27},
    '{5'd1,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd3 },
    '{5'd29, 5'd28, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27},
    '{5'd2,  5'd3,  5'd4,  5'd5,  5'd2,  5'd2,  5'd2 },
    '{5'd15, 5'd14, 5'd16, 5'd13, 5'd17, 5'd17, 5'd17},
    '{5'd28, 5'd27, 5'd26, 5'd25, 5'd28, 5'd28, 5'd28}
  };

  // Per-pixel data that travels beside the number through the digit stages.
  typedef struct packed {
    logic       black;
    logic       in_box;
    logic [2:0] k;
    logic [2:0] frow;
    logic [2:0] fcol;
    logic [5:0] color;
  } tgp_side_t;

  // Running quotient and the digit picked up for this pixel.
  typedef struct packed {
    logic [16:0] q;
    logic [3:0]  digit;
    logic        hit;
  } tgp_dig_t;

  function automatic logic tgp_on_arrow(input logic [3:0] kind, input logic [4:0] r,
                                        input logic [4:0] c);
    logic found;
    found = 1'b0;
    if (kind != ArrowNone && kind <= ArrowLast) begin
      for (int i = 0; i < 7; i++) begin
        if (ArrowRow[kind][i] == r && ArrowCol[kind][i] == c) begin
          found = 1'b1;
        end
      end
    end
    return found;
  endfunction

  function automatic logic [4:0] tgp_font_row(input logic [3:0] digit, input logic [2:0] row);
    logic [4:0] bits;
    bits = 5'd0;
    if (digit <= 4'd9 && row <= 3'd6) begin
      bits = FontRows[digit][row];
    end
    return bits;
  endfunction

endpackage

/* hw/rtl/tile_glyph_pixel_generator_top.sv */
// Pixel colour generator for one 31x31 map tile.
//
// Input channel: present a pixel's row, column and its tile's attributes
// (fill colour, arrow kind, optional number) and raise start. busy is held
// low, so a word is taken at every rising edge with start high and a new
// pixel may be offered in every cycle.
// Output channel: valid_o is high for exactly one cycle with red_o, green_o
// and blue_o; the word is taken at the edge that ends that cycle. The
// receiver cannot stall the block.
// The result passes through the input register, one divide-by-ten stage per
// decimal digit slot, and the font lookup stage that registers the colour;
// throughput is one pixel per clock.
// Reset: rst_ni clears every valid bit at once; words in flight are dropped.
module tile_glyph_pixel_generator_top import tgp_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  pixel_row_i,
  input  logic [4:0]  pixel_col_i,
  input  logic [5:0]  tile_color_i,
  input  logic [3:0]  arrow_kind_i,
  input  logic        show_number_i,
  input  logic [16:0] number_i,
  output logic        valid_o,
  output logic [1:0]  red_o,
  output logic [1:0]  green_o,
  output logic [1:0]  blue_o
);

  logic      valid_s [MAX_DIGITS+1];
  tgp_side_t side_s  [MAX_DIGITS+1];
  tgp_dig_t  dig_s   [MAX_DIGITS+1];

  assign busy = 1'b0;

  tgp_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start && !busy),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .tile_color_i (tile_color_i),
    .arrow_kind_i (arrow_kind_i),
    .show_number_i(show_number_i),
    .number_i     (number_i),
    .valid_o      (valid_s[0]),
    .side_o       (side_s[0]),
    .dig_o        (dig_s[0])
  );

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_div
    tgp_div_stage #(
      .IDX(i)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .side_i (side_s[i]),
      .dig_i  (dig_s[i]),
      .valid_o(valid_s[i+1]),
      .side_o (side_s[i+1]),
      .dig_o  (dig_s[i+1])
    );
  end

  tgp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_s[MAX_DIGITS]),
    .side_i (side_s[MAX_DIGITS]),
    .dig_i  (dig_s[MAX_DIGITS]),
    .valid_o(valid_o),
    .red_o  (red_o),
    .green_o(green_o),
    .blue_o (blue_o)
  );

endmodule

/* hw/rtl/tgp_front.sv */
module tgp_front import tgp_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [4:0]  pixel_row_i,
  input  logic [4:0]  pixel_col_i,
  input  logic [5:0]  tile_color_i,
  input  logic [3:0]  arrow_kind_i,
  input  logic        show_number_i,
  input  logic [16:0] number_i,
  output logic        valid_o,
  output tgp_side_t   side_o,
  output tgp_dig_t    dig_o
);

  localparam logic [2:0] MaxK = 3'(MAX_DIGITS);

  logic       valid_q;
  tgp_side_t  side_d, side_q;
  tgp_dig_t   dig_d, dig_q;
  logic [2:0] k;
  logic [2:0] j;

  // Digit slot counted from the right, and the column within that slot.
  always_comb begin
    if (pixel_col_i >= UnitsCol) begin
      k = 3'd0;
      j = 3'(pixel_col_i - UnitsCol);
    end else if (pixel_col_i >= UnitsCol - DigitW) begin
      k = 3'd1;
      j = 3'(pixel_col_i - (UnitsCol - DigitW));
    end else if (pixel_col_i >= UnitsCol - 5'd2 * DigitW) begin
      k = 3'd2;
      j = 3'(pixel_col_i - (UnitsCol - 5'd2 * DigitW));
    end else if (pixel_col_i >= UnitsCol - 5'd3 * DigitW) begin
      k = 3'd3;
      j = 3'(pixel_col_i - (UnitsCol - 5'd3 * DigitW));
    end else begin
      k = 3'd4;
      j = 3'(pixel_col_i);
    end
  end

  always_comb begin
    side_d.black  = (pixel_row_i == 5'd0) || (pixel_col_i == 5'd0) ||
                    (pixel_row_i >= TileLast) || (pixel_col_i >= TileLast) ||
                    tgp_on_arrow(arrow_kind_i, pixel_row_i, pixel_col_i);
    side_d.in_box = show_number_i && (pixel_row_i >= NumTop) && (pixel_row_i <= NumBot) &&
                    (pixel_col_i <= LastCol) && (k < MaxK);
    side_d.k      = k;
    side_d.frow   = 3'(pixel_row_i - NumTop);
    side_d.fcol   = j;
    side_d.color  = tile_color_i;
    dig_d.q       = number_i;
    dig_d.digit   = 4'd0;
    dig_d.hit     = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d;
    dig_q  <= dig_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dig_o   = dig_q;

endmodule

/* hw/rtl/tgp_div_stage.sv */
module tgp_div_stage import tgp_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  tgp_side_t side_i,
  input  tgp_dig_t  dig_i,
  output logic      valid_o,
  output tgp_side_t side_o,
  output tgp_dig_t  dig_o
);

  logic        valid_q;
  tgp_side_t   side_q;
  tgp_dig_t    dig_d, dig_q;
  logic [36:0] prod;
  logic [13:0] qn;
  logic [16:0] qn10;
  logic [16:0] diff;

  always_comb begin
    prod = 37'(dig_i.q) * 37'(Recip10);
    qn   = prod[36:RecipShft];
    qn10 = 17'({qn, 3'b000}) + 17'({qn, 1'b0});
    diff = dig_i.q - qn10;

    dig_d   = dig_i;
    dig_d.q = 17'(qn);
    // This slot's digit is shown only if the number still has digits left here.
    if (side_i.k == 3'(IDX)) begin
      dig_d.hit   = side_i.in_box && (dig_i.q != 17'd0);
      dig_d.digit = diff[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    dig_q  <= dig_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dig_o   = dig_q;

endmodule

/* hw/rtl/tgp_back.sv */
module tgp_back import tgp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  tgp_side_t  side_i,
  input  tgp_dig_t   dig_i,
  output logic       valid_o,
  output logic [1:0] red_o,
  output logic [1:0] green_o,
  output logic [1:0] blue_o
);

  logic       valid_q;
  logic [5:0] color_d, color_q;
  logic [4:0] font_bits;
  logic       font_on;

  always_comb begin
    font_bits = tgp_font_row(dig_i.digit, side_i.frow);
    font_on   = font_bits[3'd4 - side_i.fcol];
    if (side_i.black || (dig_i.hit && font_on)) begin
      color_d = 6'd0;
    end else begin
      color_d = side_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
  end

  assign valid_o = valid_q;
  assign red_o   = color_q[5:4];
  assign green_o = color_q[3:2];
  assign blue_o  = color_q[1:0];

endmodule

/* hw/rtl/tgp_checker.sv */
module tgp_checker import tgp_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [4:0]  pixel_row_i,
  input logic [4:0]  pixel_col_i,
  input logic [5:0]  tile_color_i,
  input logic [3:0]  arrow_kind_i,
  input logic        show_number_i,
  input logic        valid_o,
  input logic [1:0]  red_o,
  input logic [1:0]  green_o,
  input logic [1:0]  blue_o
);

  localparam int Lat = MAX_DIGITS + 2;

  logic border;
  logic plain;

  assign border = (pixel_row_i == 5'd0) || (pixel_col_i == 5'd0) ||
                  (pixel_row_i >= TileLast) || (pixel_col_i >= TileLast);
  assign plain  = !show_number_i && ((arrow_kind_i == ArrowNone) || (arrow_kind_i > ArrowLast));

  // Every accepted word comes out after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat valid_o)
    else $error("accepted word did not produce a result on time");

  // No result appears without a word accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, Lat))
    else $error("result without a matching accepted word");

  // Border pixels are always black.
  a_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(border, Lat)) |-> ({red_o, green_o, blue_o} == 6'd0))
    else $error("border pixel not black");

  // Without an arrow or a number, inner pixels carry the fill colour.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(!border && plain, Lat)) |->
      ({red_o, green_o, blue_o} == $past(tile_color_i, Lat)))
    else $error("inner pixel lost its fill colour");

endmodule

bind tile_glyph_pixel_generator_top tgp_checker #(
  .MAX_DIGITS(MAX_DIGITS)
) u_tgp_checker (.*);
